// ----- sv/grid_maze_reachability_assert.svh -----
// ---------------------------------------------------------------------------
// Grid maze reachability assertion macros
// Clocked, reset-qualified implication checks shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef GRID_MAZE_REACHABILITY_ASSERT_SVH
`define GRID_MAZE_REACHABILITY_ASSERT_SVH

// same-cycle implication
`define GMR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GMR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gmr_pkg.sv -----
// ---------------------------------------------------------------------------
// Grid maze reachability package
// Shared types and fixed widths for the grid maze search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmr_pkg;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] SIDE_RESET = 6'd32;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_TEST  = 7'b0000100,
        ST_POP   = 7'b0001000,
        ST_CELL  = 7'b0010000,
        ST_NB    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

endpackage

// ----- sv/grid_maze_reachability.sv -----
// ---------------------------------------------------------------------------
// Grid maze reachability
// Loads an n x n wall grid, then runs a stack-based depth-first search from
// the top-left cell and reports whether the bottom-right cell is reachable.
// ---------------------------------------------------------------------------
//  Channel  Handshake         Payload
//  input    s_valid/s_ready   s_is_wall   (one cell per beat, row-major)
//  result   m_valid/m_ready   m_reachable (one beat per grid)
//  config   cfg_wr_en         cfg_wr_data (side_length, 6 bits)
//
//  Cells load one per cycle; ready drops after the last cell of a grid.
//  Search: a start step tests the top-left cell; each reached cell is then popped
//  and read back from the stack, and up to 4 neighbour probes follow, each a select
//  step and a test step, set by the single read port of the wall and visited maps.
//  The hand-off waits while the previous result is still held.
//  A waiting result sits in the output register while the next grid loads.
//  Reset is synchronous; the visited map is cleared as each cell is loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_maze_reachability #(
    parameter int MAX_SIDE = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [gmr_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_is_wall,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_reachable
);

    localparam int SW    = $clog2(MAX_SIDE);
    localparam int NW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * SW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);

    gmr_pkg::state_t state_reg, state_next;
    gmr_pkg::dir_t   dir_reg, dir_next;

    logic [gmr_pkg::CFG_W-1:0] side_reg;
    logic [SW-1:0] ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic [SW-1:0] cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic [AW-1:0] cand_reg, cand_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic          found_reg, found_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_reach_reg, m_reach_next;

    logic          wall_rd_reg, vis_rd_reg;
    logic [AW-1:0] stk_rd_reg;

    logic          wall_mem [0:(2**AW)-1];
    logic          vis_mem  [0:(2**AW)-1];
    logic [AW-1:0] stk_mem  [0:CELLS-1];

    logic [NW-1:0] side_act;
    logic [SW-1:0] last_idx;
    logic          load_acc, last_cell, push;
    logic          vis_we, vis_wdata;
    logic [AW-1:0] ld_addr, vis_waddr;
    logic [PW-1:0] sp_dec;
    logic          nb_ok;
    logic [SW-1:0] nb_row, nb_col;

    always_comb begin
        if (side_reg == '0) begin
            side_act = NW'(1);
        end else if ({1'b0, side_reg} > (gmr_pkg::CFG_W + 1)'(MAX_SIDE)) begin
            side_act = NW'(MAX_SIDE);
        end else begin
            side_act = NW'(side_reg);
        end
    end

    assign last_idx  = SW'(side_act - NW'(1));
    assign s_ready   = (state_reg == gmr_pkg::ST_LOAD);
    assign load_acc  = s_valid && s_ready;
    assign last_cell = (ld_row_reg == last_idx) && (ld_col_reg == last_idx);
    assign ld_addr   = {ld_row_reg, ld_col_reg};
    assign push      = (state_reg == gmr_pkg::ST_TEST) && !wall_rd_reg && !vis_rd_reg;
    assign vis_we    = load_acc || push;
    assign vis_waddr = load_acc ? ld_addr : cand_reg;
    assign vis_wdata = push;
    assign sp_dec    = sp_reg - PW'(1);
    assign m_valid     = m_valid_reg;
    assign m_reachable = m_reach_reg;

    always_comb begin
        nb_ok  = 1'b0;
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        case (dir_reg)
            gmr_pkg::DIR_UP: begin
                nb_ok  = (cur_row_reg != '0);
                nb_row = cur_row_reg - SW'(1);
            end
            gmr_pkg::DIR_DOWN: begin
                nb_ok  = (cur_row_reg != last_idx);
                nb_row = cur_row_reg + SW'(1);
            end
            gmr_pkg::DIR_LEFT: begin
                nb_ok  = (cur_col_reg != '0);
                nb_col = cur_col_reg - SW'(1);
            end
            gmr_pkg::DIR_RIGHT: begin
                nb_ok  = (cur_col_reg != last_idx);
                nb_col = cur_col_reg + SW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        ld_row_next  = ld_row_reg;
        ld_col_next  = ld_col_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        cand_next    = cand_reg;
        sp_next      = sp_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_reach_next = m_reach_reg;

        case (state_reg)
            gmr_pkg::ST_LOAD: begin
                if (cfg_wr_en) begin
                    ld_row_next = '0;
                    ld_col_next = '0;
                end else if (load_acc) begin
                    if (last_cell) begin
                        ld_row_next = '0;
                        ld_col_next = '0;
                        sp_next     = '0;
                        state_next  = gmr_pkg::ST_START;
                    end else if (ld_col_reg == last_idx) begin
                        ld_col_next = '0;
                        ld_row_next = ld_row_reg + SW'(1);
                    end else begin
                        ld_col_next = ld_col_reg + SW'(1);
                    end
                end
            end
            gmr_pkg::ST_START: begin
                cand_next  = '0;
                dir_next   = gmr_pkg::DIR_RIGHT;
                state_next = gmr_pkg::ST_TEST;
            end
            gmr_pkg::ST_TEST: begin
                if (push) begin
                    sp_next = sp_reg + PW'(1);
                end
                if (dir_reg == gmr_pkg::DIR_RIGHT) begin
                    state_next = gmr_pkg::ST_POP;
                end else begin
                    dir_next   = gmr_pkg::dir_t'(dir_reg + 2'd1);
                    state_next = gmr_pkg::ST_NB;
                end
            end
            gmr_pkg::ST_POP: begin
                if (sp_reg == '0) begin
                    found_next = 1'b0;
                    state_next = gmr_pkg::ST_DONE;
                end else begin
                    sp_next    = sp_dec;
                    state_next = gmr_pkg::ST_CELL;
                end
            end
            gmr_pkg::ST_CELL: begin
                cur_row_next = stk_rd_reg[AW-1:SW];
                cur_col_next = stk_rd_reg[SW-1:0];
                if ((stk_rd_reg[AW-1:SW] == last_idx) &&
                    (stk_rd_reg[SW-1:0] == last_idx)) begin
                    found_next = 1'b1;
                    state_next = gmr_pkg::ST_DONE;
                end else begin
                    dir_next   = gmr_pkg::DIR_UP;
                    state_next = gmr_pkg::ST_NB;
                end
            end
            gmr_pkg::ST_NB: begin
                if (nb_ok) begin
                    cand_next  = {nb_row, nb_col};
                    state_next = gmr_pkg::ST_TEST;
                end else if (dir_reg == gmr_pkg::DIR_RIGHT) begin
                    state_next = gmr_pkg::ST_POP;
                end else begin
                    dir_next = gmr_pkg::dir_t'(dir_reg + 2'd1);
                end
            end
            gmr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_reach_next = found_reg;
                    sp_next      = '0;
                    state_next   = gmr_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = gmr_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gmr_pkg::ST_LOAD;
            dir_reg     <= gmr_pkg::DIR_UP;
            side_reg    <= gmr_pkg::SIDE_RESET;
            ld_row_reg  <= '0;
            ld_col_reg  <= '0;
            sp_reg      <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            ld_row_reg  <= ld_row_next;
            ld_col_reg  <= ld_col_next;
            sp_reg      <= sp_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                side_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        cand_reg    <= cand_next;
        m_reach_reg <= m_reach_next;
    end

    // wall and visited maps: one write, one read a cycle, registered data
    always_ff @(posedge aclk) begin
        if (load_acc) begin
            wall_mem[ld_addr] <= s_is_wall;
        end
        wall_rd_reg <= wall_mem[cand_next];
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[cand_next];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            stk_mem[sp_reg[CW-1:0]] <= cand_reg;
        end
        stk_rd_reg <= stk_mem[sp_dec[CW-1:0]];
    end

    `include "grid_maze_reachability_assert.svh"

    `GMR_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= PW'(CELLS), "stack pointer beyond grid size")
    `GMR_ASSERT_NXT(a_push_inc, push, sp_reg == $past(sp_reg) + PW'(1), "push lost")
    `GMR_ASSERT_NXT(a_empty_miss, (state_reg == gmr_pkg::ST_POP) && (sp_reg == '0),
                    (state_reg == gmr_pkg::ST_DONE) && !found_reg,
                    "empty stack not reported as miss")
    `GMR_ASSERT_IMP(a_res_src, $rose(m_valid_reg), $past(state_reg == gmr_pkg::ST_DONE),
                    "result without finished search")

endmodule
